@@ src/lfsm_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lfsm_pkg
// Shared types and codes for the latest-frame slot manager.
// ---------------------------------------------------------------------------
package lfsm_pkg;

    localparam int SLOTS_DEFAULT = 4;
    localparam int SLOT_IDX_W    = 3;

    typedef enum logic [2:0] {
        OP_CLAIM   = 3'd0,
        OP_PUBLISH = 3'd1,
        OP_ABANDON = 3'd2,
        OP_ACQUIRE = 3'd3,
        OP_RELEASE = 3'd4,
        OP_READ    = 3'd5,
        OP_RSVD6   = 3'd6,
        OP_RSVD7   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_WRITING = 2'd1,
        ST_READY   = 2'd2,
        ST_READING = 2'd3
    } slot_state_t;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_OVERWRITE = 3'd1;
    localparam logic [2:0] STS_NO_SLOT   = 3'd2;
    localparam logic [2:0] STS_INVALID   = 3'd3;
    localparam logic [2:0] STS_NONE      = 3'd4;

    localparam logic [3:0] SEL_OVERWRITTEN = 4'd0;
    localparam logic [3:0] SEL_NO_SLOT     = 4'd1;
    localparam logic [3:0] SEL_INVALID     = 4'd2;
    localparam logic [3:0] SEL_PRODUCED    = 4'd3;
    localparam logic [3:0] SEL_SKIPPED     = 4'd4;
    localparam logic [3:0] SEL_ACQUIRED    = 4'd5;
    localparam logic [3:0] SEL_CNT_FREE    = 4'd6;
    localparam logic [3:0] SEL_CNT_WRITING = 4'd7;
    localparam logic [3:0] SEL_CNT_READY   = 4'd8;
    localparam logic [3:0] SEL_CNT_READING = 4'd9;

    typedef enum logic [2:0] {
        C_IDLE,
        C_SCAN,
        C_EXEC,
        C_OUT
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the request beat
        logic scan_clear; // reset the search
        logic scan_step;  // examine one slot
        logic exec;       // commit the request
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
    } dp_sts_t;

endpackage
`default_nettype wire

@@ src/lfsm_datapath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lfsm_datapath
// Slot tables, serial slot search, counters and result register.
// ---------------------------------------------------------------------------
module lfsm_datapath #(
    parameter int SLOTS = lfsm_pkg::SLOTS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lfsm_pkg::dp_cmd_t               cmd,
    output lfsm_pkg::dp_sts_t                    sts,
    input  wire logic [2:0]                      op,
    input  wire logic [2:0]                      slot,
    input  wire logic [31:0]                     generation_in,
    input  wire logic [31:0]                     frame_sequence,
    input  wire logic [63:0]                     frame_time_ns,
    input  wire logic [3:0]                      counter_select,
    output logic [2:0]                           status,
    output logic [2:0]                           slot_out,
    output logic [31:0]                          generation_out,
    output logic [31:0]                          sequence_out,
    output logic [63:0]                          time_out_ns,
    output logic [63:0]                          publish_number_out,
    output logic [2:0]                           skipped_now,
    output logic [31:0]                          counter_value
);
    import lfsm_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    slot_state_t       st_reg [SLOTS];
    logic [31:0]       gen_reg [SLOTS];
    logic [31:0]       seq_mem [SLOTS];
    logic [63:0]       time_mem [SLOTS];
    logic [63:0]       pub_reg [SLOTS];
    logic [63:0]       last_pub_reg;
    logic [31:0]       cnt_reg [6];

    op_t               op_reg;
    logic [2:0]        slot_reg;
    logic [31:0]       gin_reg;
    logic [31:0]       seqin_reg;
    logic [63:0]       timein_reg;
    logic [3:0]        sel_reg;

    // serial search state
    logic [IW-1:0]     idx_reg;
    logic              free_hit_reg;
    logic [IW-1:0]     free_idx_reg;
    logic              old_hit_reg;
    logic [IW-1:0]     old_idx_reg;
    logic              new_hit_reg;
    logic [IW-1:0]     new_idx_reg;
    logic [CW-1:0]     nfree_reg, nwr_reg, nrdy_reg, nrdg_reg;

    assign sts.scan_last = (idx_reg == IW'(SLOTS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op_t'(op);
            slot_reg   <= slot;
            gin_reg    <= generation_in;
            seqin_reg  <= frame_sequence;
            timein_reg <= frame_time_ns;
            sel_reg    <= counter_select;
        end
    end

    // one slot per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            free_hit_reg <= 1'b0;
            free_idx_reg <= '0;
            old_hit_reg  <= 1'b0;
            old_idx_reg  <= '0;
            new_hit_reg  <= 1'b0;
            new_idx_reg  <= '0;
            nfree_reg    <= '0;
            nwr_reg      <= '0;
            nrdy_reg     <= '0;
            nrdg_reg     <= '0;
        end
        else if (cmd.scan_clear)
        begin
            idx_reg      <= '0;
            free_hit_reg <= 1'b0;
            old_hit_reg  <= 1'b0;
            new_hit_reg  <= 1'b0;
            nfree_reg    <= '0;
            nwr_reg      <= '0;
            nrdy_reg     <= '0;
            nrdg_reg     <= '0;
        end
        else if (cmd.scan_step)
        begin
            case (st_reg[idx_reg])
                ST_FREE:
                begin
                    nfree_reg <= nfree_reg + CW'(1);
                    if (!free_hit_reg)
                    begin
                        free_hit_reg <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end
                end
                ST_WRITING: nwr_reg <= nwr_reg + CW'(1);
                ST_READY:
                begin
                    nrdy_reg <= nrdy_reg + CW'(1);
                    if (!old_hit_reg || pub_reg[idx_reg] < pub_reg[old_idx_reg])
                    begin
                        old_hit_reg <= 1'b1;
                        old_idx_reg <= idx_reg;
                    end
                    if (!new_hit_reg || pub_reg[idx_reg] > pub_reg[new_idx_reg])
                    begin
                        new_hit_reg <= 1'b1;
                        new_idx_reg <= idx_reg;
                    end
                end
                default: nrdg_reg <= nrdg_reg + CW'(1);
            endcase
            if (!sts.scan_last)
                idx_reg <= idx_reg + IW'(1);
        end
    end

    // commit decode
    logic          in_range;
    logic [IW-1:0] s_idx;
    logic [IW-1:0] claim_idx;
    logic          claim_ok;

    assign in_range  = ({29'd0, slot_reg} < 32'(SLOTS));
    assign s_idx     = in_range ? slot_reg[IW-1:0] : '0;
    assign claim_ok  = free_hit_reg || old_hit_reg;
    assign claim_idx = free_hit_reg ? free_idx_reg : old_idx_reg;

    logic [31:0] claim_gen;
    assign claim_gen = gen_reg[claim_idx] + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                st_reg[i]  <= ST_FREE;
                gen_reg[i] <= '0;
                pub_reg[i] <= '0;
            end
            for (int k = 0; k < 6; k++)
                cnt_reg[k] <= '0;
            last_pub_reg <= '0;
        end
        else if (cmd.exec)
        begin
            unique case (op_reg)
                OP_CLAIM:
                begin
                    if (claim_ok)
                    begin
                        st_reg[claim_idx]  <= ST_WRITING;
                        gen_reg[claim_idx] <= claim_gen;
                        if (!free_hit_reg)
                            cnt_reg[0] <= cnt_reg[0] + 32'd1;
                    end
                    else
                        cnt_reg[1] <= cnt_reg[1] + 32'd1;
                end
                OP_PUBLISH:
                begin
                    if (!in_range || st_reg[s_idx] != ST_WRITING)
                        cnt_reg[2] <= cnt_reg[2] + 32'd1;
                    else
                    begin
                        last_pub_reg   <= last_pub_reg + 64'd1;
                        pub_reg[s_idx] <= last_pub_reg + 64'd1;
                        st_reg[s_idx]  <= ST_READY;
                        cnt_reg[3]     <= cnt_reg[3] + 32'd1;
                    end
                end
                OP_ABANDON:
                begin
                    if (!in_range || st_reg[s_idx] != ST_WRITING)
                        cnt_reg[2] <= cnt_reg[2] + 32'd1;
                    else
                        st_reg[s_idx] <= ST_FREE;
                end
                OP_ACQUIRE:
                begin
                    if (new_hit_reg)
                    begin
                        // newest ready slot goes to Reading, the rest are freed
                        for (int i = 0; i < SLOTS; i++)
                            if (st_reg[i] == ST_READY)
                                st_reg[i] <= (i == int'(new_idx_reg)) ? ST_READING
                                                                      : ST_FREE;
                        cnt_reg[4] <= cnt_reg[4] + 32'(nrdy_reg) - 32'd1;
                        cnt_reg[5] <= cnt_reg[5] + 32'd1;
                    end
                end
                OP_RELEASE:
                begin
                    if (!in_range || st_reg[s_idx] != ST_READING
                        || gen_reg[s_idx] != gin_reg)
                        cnt_reg[2] <= cnt_reg[2] + 32'd1;
                    else
                        st_reg[s_idx] <= ST_FREE;
                end
                default: ;
            endcase
        end
    end

    // payload stores, written on a good publish
    always_ff @(posedge clk)
    begin
        if (cmd.exec && op_reg == OP_PUBLISH && in_range && st_reg[s_idx] == ST_WRITING)
        begin
            seq_mem[s_idx]  <= seqin_reg;
            time_mem[s_idx] <= timein_reg;
        end
    end

    // result decode
    logic [2:0]  status_next;
    logic [2:0]  slot_out_next;
    logic [31:0] generation_out_next;
    logic [63:0] publish_number_out_next;
    logic [2:0]  skipped_now_next;
    logic [31:0] counter_value_next;

    always_comb
    begin
        status_next             = STS_OK;
        slot_out_next           = '0;
        generation_out_next     = '0;
        publish_number_out_next = '0;
        skipped_now_next        = '0;
        counter_value_next      = '0;
        unique case (op_reg) inside
            OP_CLAIM:
            begin
                if (claim_ok)
                begin
                    status_next         = free_hit_reg ? STS_OK : STS_OVERWRITE;
                    slot_out_next       = 3'(claim_idx);
                    generation_out_next = claim_gen;
                end
                else
                    status_next = STS_NO_SLOT;
            end
            OP_PUBLISH, OP_ABANDON:
                if (!in_range || st_reg[s_idx] != ST_WRITING)
                    status_next = STS_INVALID;
            OP_ACQUIRE:
            begin
                if (new_hit_reg)
                begin
                    slot_out_next           = 3'(new_idx_reg);
                    generation_out_next     = gen_reg[new_idx_reg];
                    publish_number_out_next = pub_reg[new_idx_reg];
                    skipped_now_next        = 3'(nrdy_reg - CW'(1));
                end
                else
                    status_next = STS_NONE;
            end
            OP_RELEASE:
                if (!in_range || st_reg[s_idx] != ST_READING
                    || gen_reg[s_idx] != gin_reg)
                    status_next = STS_INVALID;
            OP_READ:
            begin
                case (sel_reg)
                    SEL_OVERWRITTEN: counter_value_next = cnt_reg[0];
                    SEL_NO_SLOT:     counter_value_next = cnt_reg[1];
                    SEL_INVALID:     counter_value_next = cnt_reg[2];
                    SEL_PRODUCED:    counter_value_next = cnt_reg[3];
                    SEL_SKIPPED:     counter_value_next = cnt_reg[4];
                    SEL_ACQUIRED:    counter_value_next = cnt_reg[5];
                    SEL_CNT_FREE:    counter_value_next = 32'(nfree_reg);
                    SEL_CNT_WRITING: counter_value_next = 32'(nwr_reg);
                    SEL_CNT_READY:   counter_value_next = 32'(nrdy_reg);
                    SEL_CNT_READING: counter_value_next = 32'(nrdg_reg);
                    default:         counter_value_next = '0;
                endcase
            end
            default: status_next = STS_INVALID;
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status             <= status_next;
            slot_out           <= slot_out_next;
            generation_out     <= generation_out_next;
            publish_number_out <= publish_number_out_next;
            skipped_now        <= skipped_now_next;
            counter_value      <= counter_value_next;
        end
    end

    // stored payload of the acquired slot
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (op_reg == OP_ACQUIRE && new_hit_reg)
            begin
                sequence_out <= seq_mem[new_idx_reg];
                time_out_ns  <= time_mem[new_idx_reg];
            end
            else
            begin
                sequence_out <= '0;
                time_out_ns  <= '0;
            end
        end
    end

endmodule
`default_nettype wire

@@ src/lfsm_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lfsm_ctrl
// Sequencer: take a beat, scan the slots, commit, hold the result.
// ---------------------------------------------------------------------------
module lfsm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output lfsm_pkg::dp_cmd_t      cmd,
    input  wire lfsm_pkg::dp_sts_t sts
);
    import lfsm_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE: if (in_valid) state_next = C_SCAN;
            C_SCAN: if (sts.scan_last) state_next = C_EXEC;
            C_EXEC: state_next = C_OUT;
            C_OUT:
            begin
                if (!out_stall)
                    state_next = in_valid ? C_SCAN : C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.load       = in_valid;
                cmd.scan_clear = 1'b1;
            end
            C_SCAN: cmd.scan_step = 1'b1;
            C_EXEC: cmd.exec = 1'b1;
            C_OUT:
            begin
                out_valid      = 1'b1;
                in_stall       = out_stall;
                cmd.load       = !out_stall && in_valid;
                cmd.scan_clear = 1'b1;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ src/latest_frame_slot_manager.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// latest_frame_slot_manager
// An accepted request beat is registered, then the serial slot scan examines
// one slot per cycle, then the request is committed and the result beat held.
// The next request is not taken until the result beat of the last one leaves.
// A new request is taken in the same cycle the result beat leaves.
// Reset (rst_n low, async): all slots Free, generations, publish numbers
// and counters zero; stored sequence and timestamp are left unset.
// ---------------------------------------------------------------------------
module latest_frame_slot_manager #(
    parameter int SLOTS = lfsm_pkg::SLOTS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  op,
    input  wire logic [2:0]  slot,
    input  wire logic [31:0] generation_in,
    input  wire logic [31:0] frame_sequence,
    input  wire logic [63:0] frame_time_ns,
    input  wire logic [3:0]  counter_select,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [2:0]       slot_out,
    output logic [31:0]      generation_out,
    output logic [31:0]      sequence_out,
    output logic [63:0]      time_out_ns,
    output logic [63:0]      publish_number_out,
    output logic [2:0]       skipped_now,
    output logic [31:0]      counter_value
);
    import lfsm_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // control: idle -> scan (one slot a cycle) -> commit -> result beat
    lfsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // slot tables, search registers, counters and result register
    lfsm_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .op                 (op),
        .slot               (slot),
        .generation_in      (generation_in),
        .frame_sequence     (frame_sequence),
        .frame_time_ns      (frame_time_ns),
        .counter_select     (counter_select),
        .status             (status),
        .slot_out           (slot_out),
        .generation_out     (generation_out),
        .sequence_out       (sequence_out),
        .time_out_ns        (time_out_ns),
        .publish_number_out (publish_number_out),
        .skipped_now        (skipped_now),
        .counter_value      (counter_value)
    );

endmodule
`default_nettype wire
